/* rtl/lsd_pkg.sv */
// ----------------------------------------------------------------------------
// lsd_pkg: shared types and constants for the light schedule dimmer
// Schedule register layout, action and light state codes, minute helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package lsd_pkg;

  localparam int unsigned SCHED_W  = 43;
  localparam int unsigned MIN_W    = 11;
  localparam int unsigned RAMP_W   = 10;
  localparam int unsigned BRIGHT_W = 8;
  localparam int unsigned STATE_W  = 3;
  localparam int unsigned ACT_W    = 2;
  localparam int unsigned OVR_W    = 2;
  localparam int unsigned NUM_W    = 19;  // ramp minutes * 255, up to 1440 * 255
  localparam int unsigned SMIN_W   = 13;  // signed minute arithmetic

  localparam logic [MIN_W-1:0]    DAY_MINS    = 11'd1440;
  localparam logic [BRIGHT_W-1:0] FULL_BRIGHT = 8'd255;

  localparam logic [SCHED_W-1:0] SCHED_ZONE0_RST = 43'd4527024308584;
  localparam logic [SCHED_W-1:0] SCHED_ZONE1_RST = 43'd4527023571304;

  // item kinds
  localparam logic [ACT_W-1:0] ACT_TICK   = 2'd0;
  localparam logic [ACT_W-1:0] ACT_MAN_ON = 2'd1;
  localparam logic [ACT_W-1:0] ACT_MAN_OFF = 2'd2;
  localparam logic [ACT_W-1:0] ACT_CLEAR  = 2'd3;

  // override modes
  localparam logic [OVR_W-1:0] OVR_NONE = 2'd0;
  localparam logic [OVR_W-1:0] OVR_ON   = 2'd1;
  localparam logic [OVR_W-1:0] OVR_OFF  = 2'd2;

  // reported light states
  localparam logic [STATE_W-1:0] LS_OFF     = 3'd0;
  localparam logic [STATE_W-1:0] LS_SUNRISE = 3'd1;
  localparam logic [STATE_W-1:0] LS_ON      = 3'd2;
  localparam logic [STATE_W-1:0] LS_SUNSET  = 3'd3;
  localparam logic [STATE_W-1:0] LS_MAN_ON  = 3'd4;
  localparam logic [STATE_W-1:0] LS_MAN_OFF = 3'd5;

  // brings a signed minute difference in -2880..2879 into 0..1439
  function automatic logic [MIN_W-1:0] wrap_day(input logic signed [SMIN_W-1:0] v);
    logic signed [SMIN_W-1:0] day;
    logic signed [SMIN_W-1:0] r;
    day = $signed({2'b00, DAY_MINS});
    if (v < -day) begin
      r = v + day + day;
    end else if (v < 0) begin
      r = v + day;
    end else if (v >= day) begin
      r = v - day;
    end else begin
      r = v;
    end
    return r[MIN_W-1:0];
  endfunction

endpackage

`default_nettype wire

/* rtl/light_schedule_dimmer_unit.sv */
// ----------------------------------------------------------------------------
// light_schedule_dimmer_unit: two-zone daily light scheduler with dimming
//
// Input stream (s_*): one item per tick or manual event. s_tuser carries the
// action and zone, s_tdata the minute of the day. Output stream (m_*): one
// status item per input item, in order.
// Config port (cfg_*): cfg_index 0/1 selects the zone schedule, always ready.
// Write only while no item is in flight.
// Manual, clear, disabled, off, on and zero-ramp items go from S_EVAL
// straight to S_DONE; a ramp whose level clamps at full passes S_MUL and
// S_CHK; a ramp that needs the divide also runs S_DIV. The ramp brightness
// goes through a shared compare/subtract unit, one quotient bit per cycle.
// The next item is accepted in the cycle after the result is registered;
// the unit takes no new item until the last one is handed to the output.
// The output register holds a finished item while the receiver stalls; the
// unit accepts and computes the next item meanwhile and waits only to hand
// it over.
// Reset (rst, synchronous): schedules go to their defaults, overrides clear,
// the output stream is empty.
// ----------------------------------------------------------------------------
`default_nettype none

module light_schedule_dimmer_unit (
  input  wire logic        clk,
  input  wire logic        rst,
  // input stream
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [15:0] s_tdata,   // [10:0] current_minute, zero pad
  input  wire logic [2:0]  s_tuser,   // [1:0] action, [2] zone
  // output stream
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [23:0]      m_tdata,   // [2:0] light_state, [10:3] brightness,
                                      // [11] relay_on, [22:12] minutes_until_change
  output logic [0:0]       m_tuser,   // [0] zone_out
  // configuration writes
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [0:0]  cfg_index,
  input  wire logic [42:0] cfg_data
);

  localparam int unsigned MIN_W    = lsd_pkg::MIN_W;
  localparam int unsigned RAMP_W   = lsd_pkg::RAMP_W;
  localparam int unsigned BRIGHT_W = lsd_pkg::BRIGHT_W;
  localparam int unsigned STATE_W  = lsd_pkg::STATE_W;
  localparam int unsigned NUM_W    = lsd_pkg::NUM_W;
  localparam int unsigned SMIN_W   = lsd_pkg::SMIN_W;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_EVAL = 3'd1;
  localparam logic [2:0] S_MUL  = 3'd2;
  localparam logic [2:0] S_CHK  = 3'd3;
  localparam logic [2:0] S_DIV  = 3'd4;
  localparam logic [2:0] S_DONE = 3'd5;

  logic [2:0] state;

  logic [lsd_pkg::SCHED_W-1:0] sched [2];
  logic [lsd_pkg::OVR_W-1:0]   ovr   [2];

  // latched item
  logic [lsd_pkg::ACT_W-1:0]   act;
  logic                        zone;
  logic [MIN_W-1:0]            cur;
  logic [lsd_pkg::SCHED_W-1:0] sch;

  // result under construction
  logic [STATE_W-1:0]  r_state;
  logic [BRIGHT_W-1:0] r_bright;
  logic                r_relay;
  logic [MIN_W-1:0]    r_mins;

  // divider
  logic [MIN_W-1:0]  ramp_x;
  logic [RAMP_W-1:0] div;
  logic [NUM_W-1:0]  num;
  logic [NUM_W-1:0]  dsh;
  logic [2:0]        cnt;

  logic in_acc;
  logic [MIN_W-1:0] in_min_raw;
  logic [MIN_W-1:0] in_min;

  assign s_tready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;
  assign in_acc    = s_tvalid && s_tready;
  assign in_min_raw = s_tdata[MIN_W-1:0];
  assign in_min = (in_min_raw >= lsd_pkg::DAY_MINS) ? in_min_raw - lsd_pkg::DAY_MINS
                                                    : in_min_raw;

  // ---------------- schedule decode and state selection ----------------
  logic [MIN_W-1:0]  on_raw, off_raw, on_m, off_m;
  logic [RAMP_W-1:0] rise, set;
  logic signed [SMIN_W-1:0] on_s, off_s, cur_s, rise_end, set_start;
  logic crossing;
  logic [STATE_W-1:0] sch_state;
  logic [MIN_W-1:0]   sch_mins;
  logic [MIN_W-1:0]   sch_x;

  always_comb begin
    on_raw  = sch[10:0];
    off_raw = sch[21:11];
    rise    = sch[31:22];
    set     = sch[41:32];
    on_m    = (on_raw >= lsd_pkg::DAY_MINS) ? on_raw - lsd_pkg::DAY_MINS : on_raw;
    if (off_raw == '0) begin
      off_m = lsd_pkg::DAY_MINS;          // 0 means 24:00
    end else if (off_raw > lsd_pkg::DAY_MINS) begin
      off_m = off_raw - lsd_pkg::DAY_MINS;
    end else begin
      off_m = off_raw;
    end
    on_s      = $signed({2'b00, on_m});
    off_s     = $signed({2'b00, off_m});
    cur_s     = $signed({2'b00, cur});
    rise_end  = on_s + $signed({3'b000, rise});
    set_start = off_s - $signed({3'b000, set});
    crossing  = (off_m <= on_m);

    if (crossing) begin
      if (cur_s >= on_s) begin
        sch_state = (cur_s < rise_end) ? lsd_pkg::LS_SUNRISE : lsd_pkg::LS_ON;
      end else if (cur_s < off_s) begin
        sch_state = (cur_s >= set_start) ? lsd_pkg::LS_SUNSET : lsd_pkg::LS_ON;
      end else begin
        sch_state = lsd_pkg::LS_OFF;
      end
    end else begin
      if (cur_s < on_s) begin
        sch_state = lsd_pkg::LS_OFF;
      end else if (cur_s < rise_end) begin
        sch_state = lsd_pkg::LS_SUNRISE;
      end else if (cur_s < set_start) begin
        sch_state = lsd_pkg::LS_ON;
      end else if (cur_s < off_s) begin
        sch_state = lsd_pkg::LS_SUNSET;
      end else begin
        sch_state = lsd_pkg::LS_OFF;
      end
    end

    sch_x = '0;
    case (sch_state)
      lsd_pkg::LS_OFF: begin
        sch_mins = (cur < on_m) ? on_m - cur : lsd_pkg::DAY_MINS - cur + on_m;
      end
      lsd_pkg::LS_SUNRISE: begin
        sch_mins = lsd_pkg::wrap_day(rise_end - cur_s);
        sch_x    = lsd_pkg::wrap_day(cur_s - on_s);
      end
      lsd_pkg::LS_ON: begin
        sch_mins = lsd_pkg::wrap_day(set_start - cur_s);
      end
      default: begin
        sch_mins = lsd_pkg::wrap_day(off_s - cur_s);
        sch_x    = sch_mins;
      end
    endcase
  end

  // ---------------- sequencer ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      sched[0] <= lsd_pkg::SCHED_ZONE0_RST;
      sched[1] <= lsd_pkg::SCHED_ZONE1_RST;
      ovr[0]   <= lsd_pkg::OVR_NONE;
      ovr[1]   <= lsd_pkg::OVR_NONE;
      m_tvalid <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        sched[cfg_index] <= cfg_data;
      end

      // in S_DONE the hand-over below decides m_tvalid
      if (m_tvalid && m_tready && (state != S_DONE)) begin
        m_tvalid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (in_acc) begin
            act  <= s_tuser[1:0];
            zone <= s_tuser[2];
            cur  <= in_min;
            sch  <= sched[s_tuser[2]];
            case (s_tuser[1:0])
              lsd_pkg::ACT_MAN_ON:  ovr[s_tuser[2]] <= lsd_pkg::OVR_ON;
              lsd_pkg::ACT_MAN_OFF: ovr[s_tuser[2]] <= lsd_pkg::OVR_OFF;
              lsd_pkg::ACT_CLEAR:   ovr[s_tuser[2]] <= lsd_pkg::OVR_NONE;
              default: ;
            endcase
            state <= S_EVAL;
          end
        end
        S_EVAL: begin
          if (act == lsd_pkg::ACT_CLEAR) begin
            r_state <= lsd_pkg::LS_OFF;
            r_bright <= '0;
            r_relay <= 1'b0;
            r_mins  <= '0;
            state   <= S_DONE;
          end else if (ovr[zone] == lsd_pkg::OVR_ON) begin
            r_state <= lsd_pkg::LS_MAN_ON;
            r_bright <= lsd_pkg::FULL_BRIGHT;
            r_relay <= 1'b1;
            r_mins  <= '0;
            state   <= S_DONE;
          end else if (ovr[zone] == lsd_pkg::OVR_OFF) begin
            r_state <= lsd_pkg::LS_MAN_OFF;
            r_bright <= '0;
            r_relay <= 1'b0;
            r_mins  <= '0;
            state   <= S_DONE;
          end else if (!sch[42]) begin
            r_state <= lsd_pkg::LS_OFF;
            r_bright <= '0;
            r_relay <= 1'b0;
            r_mins  <= '0;
            state   <= S_DONE;
          end else begin
            r_state <= sch_state;
            r_relay <= (sch_state != lsd_pkg::LS_OFF);
            r_mins  <= sch_mins;
            ramp_x  <= sch_x;
            case (sch_state)
              lsd_pkg::LS_OFF: begin
                r_bright <= '0;
                state    <= S_DONE;
              end
              lsd_pkg::LS_ON: begin
                r_bright <= lsd_pkg::FULL_BRIGHT;
                state    <= S_DONE;
              end
              lsd_pkg::LS_SUNRISE: begin
                div <= rise;
                if (rise == '0) begin
                  r_bright <= lsd_pkg::FULL_BRIGHT;
                  state    <= S_DONE;
                end else begin
                  state <= S_MUL;
                end
              end
              default: begin
                div <= set;
                if (set == '0) begin
                  r_bright <= '0;
                  state    <= S_DONE;
                end else begin
                  state <= S_MUL;
                end
              end
            endcase
          end
        end
        S_MUL: begin
          // x * 255 as (x << 8) - x
          num   <= {ramp_x, 8'd0} - {8'd0, ramp_x};
          dsh   <= {2'b00, div, 7'd0};
          state <= S_CHK;
        end
        S_CHK: begin
          if (num >= {1'b0, div, 8'd0}) begin
            r_bright <= lsd_pkg::FULL_BRIGHT;  // quotient clamps
            state    <= S_DONE;
          end else begin
            cnt   <= 3'd7;
            state <= S_DIV;
          end
        end
        S_DIV: begin
          if (num >= dsh) begin
            num      <= num - dsh;
            r_bright <= {r_bright[BRIGHT_W-2:0], 1'b1};
          end else begin
            r_bright <= {r_bright[BRIGHT_W-2:0], 1'b0};
          end
          dsh <= dsh >> 1;
          cnt <= cnt - 3'd1;
          if (cnt == 3'd0) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tuser  <= zone;
            m_tdata  <= {1'b0, r_mins, r_relay, r_bright, r_state};
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire
